// ----- sv/buddy_memory_allocator_core_assert.svh -----
// assertion helpers for the buddy allocator core
`ifndef BUDDY_MEMORY_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_MEMORY_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BMA_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bma same-cycle check failed");

// next-cycle implication, checked out of reset
`define BMA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bma next-cycle check failed");

`endif

// ----- sv/bma_pkg.sv -----
`default_nettype none
package bma_pkg;

    localparam int MEM_ORDER_DEF = 16;
    localparam int MAX_NODES_DEF = 2048;

    localparam int ORD_W  = 5;
    localparam int TOT_W  = 25;
    localparam int SIZE_W = 24;
    localparam int HDR_W  = 8;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 2;
    localparam int CIDX_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAIL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_HEADER    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_ORDER = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BASE      = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_ORD,
        S_A_BKT,
        S_A_CNT,
        S_A_CNT_WT,
        S_A_HEAD,
        S_A_HEAD_WT,
        S_A_SPL,
        S_A_SPL_WT,
        S_F_WALK,
        S_F_WALK_WT,
        S_F_FREEB,
        S_F_MERGE,
        S_F_FIN
    } state_t;

endpackage
`default_nettype wire

// ----- sv/bma_ram.sv -----
`default_nettype none
module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/buddy_memory_allocator_core.sv -----
`default_nettype none
// channel | signals                                    | handshake
// --------+--------------------------------------------+---------------------------
// request | op, request_size, release_address          | start high while busy low
// result  | block_address, status                      | done high for one cycle
// config  | cfg_index, cfg_data                        | cfg_write high, no wait
//
// steps: allocate walks the order up from min_block_order to the fit, skips each empty
//   order above it, counts spare nodes, then splits; each ram read has a wait state
// free walks the allocated list, then per merged order walks the free list for the
//   buddy, and finally pushes the merged block
// reset: a clearing pass over all MAX_NODES descriptors chains them; busy stays high.
// the receiver cannot stall; each result item shows for one cycle with done.
module buddy_memory_allocator_core #(
    parameter int MEM_ORDER = bma_pkg::MEM_ORDER_DEF,
    parameter int MAX_NODES = bma_pkg::MAX_NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [bma_pkg::SIZE_W-1:0]    request_size,
    input  wire logic [bma_pkg::ADDR_W-1:0]    release_address,
    output logic                               done,
    output logic      [bma_pkg::ADDR_W-1:0]    block_address,
    output logic      [bma_pkg::STAT_W-1:0]    status,
    input  wire logic                          cfg_write,
    input  wire logic [bma_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [bma_pkg::ADDR_W-1:0]    cfg_data
);

    import bma_pkg::*;

    // node word: start offset, order, link (link holds MAX_NODES for end of list)
    localparam int NW = $clog2(MAX_NODES);
    localparam int PW = $clog2(MAX_NODES + 1);
    localparam int BW = $clog2(MEM_ORDER + 1);
    localparam int WW = MEM_ORDER + ORD_W + PW;
    localparam logic [PW-1:0]    NONE  = PW'(MAX_NODES);
    localparam logic [ORD_W-1:0] MEM_O = ORD_W'(MEM_ORDER);
    localparam logic [NW-1:0]    LAST  = NW'(MAX_NODES - 1);

    state_t state_reg, state_next;

    // configuration
    logic [HDR_W-1:0]  hdr_reg;
    logic [ORD_W-1:0]  mbo_reg;
    logic [ADDR_W-1:0] base_reg;

    // list heads
    logic [PW-1:0] bucket_reg [MEM_ORDER+1];
    logic [PW-1:0] bucket_next [MEM_ORDER+1];
    logic [PW-1:0] alloc_head_reg, alloc_head_next;
    logic [PW-1:0] spare_head_reg, spare_head_next;

    // sequencer working registers
    logic [NW-1:0]        init_idx_reg, init_idx_next;
    logic [ORD_W-1:0]     k_reg, k_next;
    logic [ORD_W-1:0]     need_reg, need_next;
    logic [ORD_W-1:0]     cnt_reg, cnt_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [PW-1:0]        ptr_reg, ptr_next;
    logic [PW-1:0]        prev_reg, prev_next;
    logic [WW-1:0]        prev_word_reg, prev_word_next;
    logic [PW-1:0]        node_reg, node_next;
    logic [MEM_ORDER-1:0] nstart_reg, nstart_next;
    logic [ADDR_W-1:0]    key_reg, key_next;
    logic                 merge_reg, merge_next;

    // result registers
    logic                 done_reg, done_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [STAT_W-1:0]    status_reg, status_next;

    // node ram ports
    logic          ram_we, ram_re;
    logic [NW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    // decoded read word and shared compares
    logic [MEM_ORDER-1:0] rd_start;
    logic [ORD_W-1:0]     rd_order;
    logic [PW-1:0]        rd_link;
    logic [BW-1:0]        kidx;
    logic [PW-1:0]        bkt_head;
    logic                 k_over, ord_more, cnt_ok, ptr_end, hit, k_low;
    logic [MEM_ORDER-1:0] kbit;

    assign rd_start = ram_rdata[WW-1 -: MEM_ORDER];
    assign rd_order = ram_rdata[PW +: ORD_W];
    assign rd_link  = ram_rdata[PW-1:0];
    assign kidx     = k_reg[BW-1:0];
    assign bkt_head = bucket_reg[kidx];
    assign kbit     = MEM_ORDER'(1) << k_reg;
    assign k_over   = k_reg > MEM_O;
    assign k_low    = k_reg < MEM_O;
    // one compare per cycle walks the order up until 2^k covers the padded size
    assign ord_more = (k_reg < ORD_W'(TOT_W)) && ((TOT_W'(1) << k_reg) < total_reg);
    assign cnt_ok   = cnt_reg == (k_reg - need_reg);
    assign ptr_end  = ptr_reg >= NONE;
    assign hit      = ADDR_W'(rd_start) == key_reg;

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign block_address = addr_reg;
    assign status        = status_reg;

    bma_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (init_idx_reg == LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = (op == OP_FREE) ? S_F_WALK : S_A_ORD;
            end
            S_A_ORD:
            begin
                if (k_over)
                    state_next = S_IDLE;
                else if (!ord_more)
                    state_next = S_A_BKT;
            end
            S_A_BKT:
            begin
                if (k_over)
                    state_next = S_IDLE;
                else if (bkt_head != NONE)
                    state_next = S_A_CNT;
            end
            S_A_CNT:
            begin
                if (cnt_ok)
                    state_next = S_A_HEAD;
                else if (ptr_end)
                    state_next = S_IDLE;
                else
                    state_next = S_A_CNT_WT;
            end
            S_A_CNT_WT:  state_next = S_A_CNT;
            S_A_HEAD:    state_next = S_A_HEAD_WT;
            S_A_HEAD_WT: state_next = S_A_SPL;
            S_A_SPL:     state_next = (k_reg > need_reg) ? S_A_SPL_WT : S_IDLE;
            S_A_SPL_WT:  state_next = S_A_SPL;
            S_F_WALK:
            begin
                if (!ptr_end)
                    state_next = S_F_WALK_WT;
                else
                    state_next = merge_reg ? S_F_FIN : S_IDLE;
            end
            S_F_WALK_WT:
            begin
                if (!hit)
                    state_next = S_F_WALK;
                else
                    state_next = merge_reg ? S_F_FREEB : S_F_MERGE;
            end
            S_F_FREEB:   state_next = S_F_MERGE;
            S_F_MERGE:   state_next = k_low ? S_F_WALK : S_F_FIN;
            S_F_FIN:     state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath, list heads, node ram and result
    always_comb
    begin
        bucket_next     = bucket_reg;
        alloc_head_next = alloc_head_reg;
        spare_head_next = spare_head_reg;
        init_idx_next   = init_idx_reg;
        k_next          = k_reg;
        need_next       = need_reg;
        cnt_next        = cnt_reg;
        total_next      = total_reg;
        ptr_next        = ptr_reg;
        prev_next       = prev_reg;
        prev_word_next  = prev_word_reg;
        node_next       = node_reg;
        nstart_next     = nstart_reg;
        key_next        = key_reg;
        merge_next      = merge_reg;
        done_next       = 1'b0;
        addr_next       = addr_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        case (state_reg)
            S_INIT:
            begin
                // chain every descriptor but node 0 as a spare, node 0 holds the whole memory
                ram_we        = 1'b1;
                ram_waddr     = init_idx_reg;
                if (init_idx_reg == '0)
                    ram_wdata = {MEM_ORDER'(0), MEM_O, NONE};
                else
                    ram_wdata = {MEM_ORDER'(0), ORD_W'(0), PW'(init_idx_reg) + PW'(1)};
                init_idx_next = init_idx_reg + NW'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    total_next = TOT_W'(request_size) + TOT_W'(hdr_reg);
                    k_next     = mbo_reg;
                    key_next   = release_address - base_reg - ADDR_W'(hdr_reg);
                    prev_next  = NONE;
                    ptr_next   = alloc_head_reg;
                    merge_next = 1'b0;
                end
            end
            S_A_ORD:
            begin
                if (k_over)
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = ST_FAIL;
                end
                else if (ord_more)
                    k_next = k_reg + ORD_W'(1);
                else
                    need_next = k_reg;
            end
            S_A_BKT:
            begin
                if (k_over)
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = ST_FAIL;
                end
                else if (bkt_head == NONE)
                    k_next = k_reg + ORD_W'(1);
                else
                begin
                    cnt_next = '0;
                    ptr_next = spare_head_reg;
                end
            end
            S_A_CNT:
            begin
                // enough spare descriptors for every split
                if (cnt_ok)
                    ;
                else if (ptr_end)
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = ST_FAIL;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[NW-1:0];
                end
            end
            S_A_CNT_WT:
            begin
                ptr_next = rd_link;
                cnt_next = cnt_reg + ORD_W'(1);
            end
            S_A_HEAD:
            begin
                node_next = bkt_head;
                ram_re    = 1'b1;
                ram_raddr = bkt_head[NW-1:0];
            end
            S_A_HEAD_WT:
            begin
                nstart_next       = rd_start;
                bucket_next[kidx] = rd_link;
            end
            S_A_SPL:
            begin
                if (k_reg > need_reg)
                begin
                    k_next    = k_reg - ORD_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = spare_head_reg[NW-1:0];
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = node_reg[NW-1:0];
                    ram_wdata       = {nstart_reg, need_reg, alloc_head_reg};
                    alloc_head_next = node_reg;
                    done_next       = 1'b1;
                    addr_next       = base_reg + ADDR_W'(hdr_reg) + ADDR_W'(nstart_reg);
                    status_next     = ST_OK;
                end
            end
            S_A_SPL_WT:
            begin
                // right half goes to the head of its list
                ram_we            = 1'b1;
                ram_waddr         = spare_head_reg[NW-1:0];
                ram_wdata         = {nstart_reg + kbit, k_reg, bkt_head};
                bucket_next[kidx] = spare_head_reg;
                spare_head_next   = rd_link;
            end
            S_F_WALK:
            begin
                if (!ptr_end)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[NW-1:0];
                end
                else if (!merge_reg)
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = ST_UNKNOWN;
                end
            end
            S_F_WALK_WT:
            begin
                if (!hit)
                begin
                    prev_next      = ptr_reg;
                    prev_word_next = ram_rdata;
                    ptr_next       = rd_link;
                end
                else
                begin
                    // unlink the node just read
                    if (prev_reg == NONE)
                    begin
                        if (merge_reg)
                            bucket_next[kidx] = rd_link;
                        else
                            alloc_head_next = rd_link;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = prev_reg[NW-1:0];
                        ram_wdata = {prev_word_reg[WW-1:PW], rd_link};
                    end
                    if (merge_reg)
                    begin
                        prev_word_next = ram_rdata;
                        if (key_reg[MEM_ORDER-1:0] < nstart_reg)
                            nstart_next = key_reg[MEM_ORDER-1:0];
                    end
                    else
                    begin
                        node_next   = ptr_reg;
                        nstart_next = rd_start;
                        k_next      = (rd_order > MEM_O) ? MEM_O : rd_order;
                    end
                end
            end
            S_F_FREEB:
            begin
                // absorbed buddy returns to the spare pool
                ram_we          = 1'b1;
                ram_waddr       = ptr_reg[NW-1:0];
                ram_wdata       = {prev_word_reg[WW-1:PW], spare_head_reg};
                spare_head_next = ptr_reg;
                k_next          = k_reg + ORD_W'(1);
            end
            S_F_MERGE:
            begin
                if (k_low)
                begin
                    key_next   = ADDR_W'(nstart_reg ^ kbit);
                    prev_next  = NONE;
                    ptr_next   = bkt_head;
                    merge_next = 1'b1;
                end
            end
            S_F_FIN:
            begin
                ram_we            = 1'b1;
                ram_waddr         = node_reg[NW-1:0];
                ram_wdata         = {nstart_reg, k_reg, bkt_head};
                bucket_next[kidx] = node_reg;
                done_next         = 1'b1;
                addr_next         = '0;
                status_next       = ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_idx_reg   <= '0;
            alloc_head_reg <= NONE;
            spare_head_reg <= PW'(1);
            done_reg       <= 1'b0;
            addr_reg       <= '0;
            status_reg     <= ST_OK;
            for (int i = 0; i <= MEM_ORDER; i++)
            begin
                bucket_reg[i] <= (i == MEM_ORDER) ? PW'(0) : NONE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            init_idx_reg   <= init_idx_next;
            alloc_head_reg <= alloc_head_next;
            spare_head_reg <= spare_head_next;
            done_reg       <= done_next;
            addr_reg       <= addr_next;
            status_reg     <= status_next;
            bucket_reg     <= bucket_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        need_reg      <= need_next;
        cnt_reg       <= cnt_next;
        total_reg     <= total_next;
        ptr_reg       <= ptr_next;
        prev_reg      <= prev_next;
        prev_word_reg <= prev_word_next;
        node_reg      <= node_next;
        nstart_reg    <= nstart_next;
        key_reg       <= key_next;
        merge_reg     <= merge_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= '0;
            mbo_reg  <= ORD_W'(5);
            base_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HEADER:    hdr_reg  <= cfg_data[HDR_W-1:0];
                CFG_MIN_ORDER: mbo_reg  <= cfg_data[ORD_W-1:0];
                CFG_BASE:      base_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

`include "buddy_memory_allocator_core_assert.svh"

    // an accepted item always leaves idle
    `BMA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // a result is a single-cycle strobe
    `BMA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // failed items carry a zero address
    `BMA_ASSERT_NOW(a_fail_zero, clk, rst_n, done && (status != ST_OK), block_address == '0)

endmodule
`default_nettype wire
